// ===== rtl/core/epr_pkg.sv =====
// Shared constants, types and codes for the e-paper pixel response model.
`default_nettype none

package epr_pkg;

    localparam int FRAME_WIDTH_DEF  = 1024;
    localparam int FRAME_HEIGHT_DEF = 768;

    localparam int ACCEL_W = 7;
    localparam int SRC_W   = 8;
    localparam int CODE_W  = 2;
    localparam int SLOTS   = 4;
    localparam int X_W     = 10;
    localparam int Y_W     = 10;
    localparam int LEVEL_W = 8;
    localparam int SPEED_W = 8;

    localparam logic [ACCEL_W-1:0] ACCEL_RESET = 7'd20;

    // drive codes; the other two codes add no acceleration
    localparam logic [CODE_W-1:0] DRV_DARKEN  = 2'd1;
    localparam logic [CODE_W-1:0] DRV_LIGHTEN = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'hff;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 8'h00;

    // 0.9 decay: |s| * 58986 >> 16 equals floor(|s| * 9 / 10) for |s| <= 128
    localparam logic [15:0] DECAY_MUL   = 16'd58986;
    localparam int          DECAY_SHIFT = 16;

    localparam int OFIFO_DEPTH = 4;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic              last;
    } t_pix_ctl;

    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } t_pix_res;

endpackage

`default_nettype wire

// ===== rtl/core/epr_if.sv =====
// Valid/ready channel interfaces for the bus sample input and pixel result output.
`default_nettype none

interface epr_in_if;
    import epr_pkg::*;

    logic             valid;
    logic             ready;
    logic             hsync;
    logic             vsync_n;
    logic             data_enable_n;
    logic [SRC_W-1:0] source_data;

    modport source (output valid, output hsync, output vsync_n, output data_enable_n,
                    output source_data, input ready);
    modport sink   (input valid, input hsync, input vsync_n, input data_enable_n,
                    input source_data, output ready);
endinterface

interface epr_out_if;
    import epr_pkg::*;

    logic               valid;
    logic               ready;
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [LEVEL_W-1:0] pixel_level;
    logic               last_of_item;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_level,
                    output last_of_item, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_level,
                    input last_of_item, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/epaper_pixel_response_model.sv =====
// Top level: e-paper pixel response model driven by source/gate bus samples.
// Input channel i_in (valid/ready): one bus sample per transaction, carrying
// hsync, vsync_n, data_enable_n and the source byte. A rising hsync starts a
// line; with data enable active the byte holds four 2-bit drive codes, bits
// 7:6 first, for four consecutive columns.
// Output channel o_out (valid/ready): one transaction per pixel inside the
// frame, with its column, row, new gray level and a flag on the last result
// of the bus sample. Samples with no pixel in the frame give no result.
// Config port: i_cfg_wr_en / i_cfg_wr_data write the acceleration step.
// Throughput: one pixel per cycle while the result queue has room, through a
// single read-modify-write port of the pixel memory; the next sample is taken
// in the cycle its last pixel issues. A pixel's result is registered in the
// update stage of the pixel memory and then in the result queue before o_out.
// Reset: synchronous, active low. A clearing pass then writes every pixel
// (level 255, speed 0); i_in.ready stays low until it ends.
// Stall: results wait in a 4-entry queue; pixel issue pauses while the queue
// plus the update pipeline hold four results, and input then backs up.
`default_nettype none

module epaper_pixel_response_model #(
    parameter int FRAME_WIDTH  = epr_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = epr_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [epr_pkg::ACCEL_W-1:0] i_cfg_wr_data,
    epr_in_if.sink                      i_in,
    epr_out_if.source                   o_out
);
    import epr_pkg::*;

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(FRAME_WIDTH + 1);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT + 1);
    localparam int PEND_W = $clog2(OFIFO_DEPTH + 1);
    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic [COL_W:0]    COL_LIMIT  = (COL_W + 1)'(FRAME_WIDTH);
    localparam logic [ROW_W-1:0]  ROW_LIMIT  = ROW_W'(FRAME_HEIGHT);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(FRAME_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(FRAME_WIDTH);
    localparam logic [PEND_W-1:0] PEND_MAX   = PEND_W'(OFIFO_DEPTH);

    // architectural line/frame tracking
    logic [ACCEL_W-1:0] r_accel;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [ADDR_W-1:0]  r_row_base;
    logic               r_prev_hsync;
    logic               r_line_had_data;

    // current sample being issued pixel by pixel
    logic [SRC_W-1:0]   r_codes;
    logic [SLOTS-1:0]   r_mask;
    logic [ADDR_W-1:0]  r_addr0;
    logic [COL_W-1:0]   r_x0;
    logic [ROW_W-1:0]   r_y;

    // results issued and not yet taken by the receiver
    logic [PEND_W-1:0]  r_pend;

    logic               in_acc;
    logic               hs_rise;
    logic [COL_W-1:0]   col_s;
    logic [ROW_W-1:0]   row_s;
    logic [ADDR_W-1:0]  base_s;
    logic               lhd_s;
    logic [SLOTS-1:0]   slot_ok;
    logic [COL_W-1:0]   col_end;

    logic               clearing;
    logic               issue;
    logic [SLOT_W-1:0]  issue_k;
    logic [SLOTS-1:0]   mask_rem;
    logic               pop;

    t_pix_ctl           op;
    logic [ADDR_W-1:0]  op_addr;
    logic               res_valid;
    t_pix_res           res;
    t_pix_res           q_data;
    logic               q_valid;

    // ---------------- sample decode ----------------
    assign hs_rise = !r_prev_hsync && i_in.hsync;

    always_comb begin
        logic [COL_W:0] sx;
        logic [COL_W:0] c4;

        col_s  = hs_rise ? '0 : r_col;
        row_s  = r_row;
        base_s = r_row_base;
        lhd_s  = r_line_had_data;
        if (hs_rise) begin
            if (!i_in.vsync_n) begin
                row_s  = '0;
                base_s = '0;
                lhd_s  = 1'b0;
            end else if (r_line_had_data && (r_row < ROW_LIMIT)) begin
                row_s = r_row + 1'b1;
                // past the bottom row the base is never used
                if (r_row < ROW_LAST) begin
                    base_s = r_row_base + ROW_STRIDE;
                end
            end
        end

        for (int k = 0; k < SLOTS; k++) begin
            sx = {1'b0, col_s} + (COL_W + 1)'(k);
            slot_ok[k] = (sx < COL_LIMIT) && (row_s < ROW_LIMIT);
        end

        // column saturates at the frame width
        c4      = {1'b0, col_s} + (COL_W + 1)'(SLOTS);
        col_end = (c4 < COL_LIMIT) ? c4[COL_W-1:0] : COL_LIMIT[COL_W-1:0];
    end

    // ---------------- pixel issue ----------------
    always_comb begin
        issue_k = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                issue_k = SLOT_W'(k);
            end
        end
    end

    assign issue    = (r_mask != '0) && (r_pend < PEND_MAX);
    assign mask_rem = r_mask & ~(SLOTS'(1) << issue_k);

    // next sample may enter in the cycle the current one issues its last pixel
    assign i_in.ready = !clearing && ((issue ? mask_rem : r_mask) == '0);
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        logic [COL_W-1:0] xf;

        xf      = r_x0 + COL_W'(issue_k);
        op.valid = issue;
        op.code  = r_codes[SRC_W - 1 - CODE_W * int'(issue_k) -: CODE_W];
        op.x     = X_W'(xf);
        op.y     = Y_W'(r_y);
        op.last  = (mask_rem == '0);
        op_addr  = r_addr0 + ADDR_W'(issue_k);
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel         <= ACCEL_RESET;
            r_col           <= '0;
            r_row           <= '0;
            r_row_base      <= '0;
            r_prev_hsync    <= 1'b0;
            r_line_had_data <= 1'b0;
            r_mask          <= '0;
            r_pend          <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_accel <= i_cfg_wr_data;
            end

            if (in_acc) begin
                r_prev_hsync <= i_in.hsync;
                r_row        <= row_s;
                r_row_base   <= base_s;
                if (!i_in.data_enable_n) begin
                    r_col           <= col_end;
                    r_line_had_data <= 1'b1;
                    r_mask          <= slot_ok;
                end else begin
                    r_col           <= col_s;
                    r_line_had_data <= lhd_s;
                    r_mask          <= '0;
                end
            end else if (issue) begin
                r_mask <= mask_rem;
            end

            r_pend <= r_pend + PEND_W'(issue) - PEND_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_codes <= i_in.source_data;
            r_addr0 <= base_s + ADDR_W'(col_s);
            r_x0    <= col_s;
            r_y     <= row_s;
        end
    end

    // ---------------- pixel memory and result queue ----------------
    epr_pixel_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_pixel_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accel     (r_accel),
        .i_op        (op),
        .i_op_addr   (op_addr),
        .o_clearing  (clearing),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    epr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_valid (q_valid),
        .i_ready (o_out.ready),
        .o_data  (q_data)
    );

    assign pop                = q_valid && o_out.ready;
    assign o_out.valid        = q_valid;
    assign o_out.pixel_x      = q_data.x;
    assign o_out.pixel_y      = q_data.y;
    assign o_out.pixel_level  = q_data.level;
    assign o_out.last_of_item = q_data.last;

endmodule

`default_nettype wire

// ===== rtl/core/epr_pixel_mem.sv =====
// Pixel state memory with read-modify-write update, write forwarding and clearing pass.
`default_nettype none

module epr_pixel_mem #(
    parameter int DEPTH  = epr_pkg::FRAME_WIDTH_DEF * epr_pkg::FRAME_HEIGHT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [epr_pkg::ACCEL_W-1:0] i_accel,
    input  epr_pkg::t_pix_ctl           i_op,
    input  logic [ADDR_W-1:0]           i_op_addr,
    output logic                        o_clearing,
    output logic                        o_res_valid,
    output epr_pkg::t_pix_res           o_res
);
    import epr_pkg::*;

    localparam int CELL_W = LEVEL_W + SPEED_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    t_pix_ctl          r_s1;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_fw_valid;
    logic [ADDR_W-1:0] r_fw_addr;
    logic [CELL_W-1:0] r_fw_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [CELL_W-1:0] cur_cell;
    logic [CELL_W-1:0] new_cell;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;

    // last cycle's write is not yet visible in the read data
    assign cur_cell = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_data : r_rd_data;

    always_comb begin
        logic [LEVEL_W-1:0]        lvl;
        logic signed [SPEED_W-1:0] spd;
        logic signed [9:0]         acc;
        logic signed [9:0]         s_sum;
        logic signed [10:0]        l_sum;
        logic signed [SPEED_W-1:0] s_clamp;
        logic                      s_neg;
        logic [SPEED_W-1:0]        mag;
        logic [23:0]               prod;
        logic [SPEED_W-1:0]        q;
        logic [LEVEL_W-1:0]        lvl_new;
        logic [SPEED_W-1:0]        spd_new;

        lvl = cur_cell[CELL_W-1 -: LEVEL_W];
        spd = $signed(cur_cell[SPEED_W-1:0]);

        if (r_s1.code == DRV_DARKEN) begin
            acc = -$signed({3'b000, i_accel});
        end else if (r_s1.code == DRV_LIGHTEN) begin
            acc = $signed({3'b000, i_accel});
        end else begin
            acc = '0;
        end

        s_sum = $signed({{2{spd[SPEED_W-1]}}, spd}) + acc;
        l_sum = $signed({3'b000, lvl}) + $signed({s_sum[9], s_sum});

        if (l_sum > 11'sd255) begin
            lvl_new = LEVEL_RESET;
        end else if (l_sum < 11'sd0) begin
            lvl_new = '0;
        end else begin
            lvl_new = l_sum[LEVEL_W-1:0];
        end

        if (s_sum > 10'sd127) begin
            s_clamp = 8'sd127;
        end else if (s_sum < -10'sd128) begin
            s_clamp = -8'sd128;
        end else begin
            s_clamp = s_sum[SPEED_W-1:0];
        end

        s_neg   = s_clamp[SPEED_W-1];
        mag     = s_neg ? SPEED_W'(-s_clamp) : SPEED_W'(s_clamp);
        prod    = mag * DECAY_MUL;
        q       = prod[DECAY_SHIFT +: SPEED_W];
        spd_new = s_neg ? SPEED_W'(-q) : q;

        new_cell = {lvl_new, spd_new};
    end

    assign wr_en   = r_clearing || r_s1.valid;
    assign wr_addr = r_clearing ? r_clr_addr : r_s1_addr;
    assign wr_data = r_clearing ? {LEVEL_RESET, SPEED_RESET} : new_cell;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[i_op_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1       <= '0;
            r_fw_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1       <= i_op;
            r_fw_valid <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_op_addr;
        r_fw_addr <= r_s1_addr;
        r_fw_data <= new_cell;
    end

    assign o_clearing  = r_clearing;
    assign o_res_valid = r_s1.valid;
    assign o_res       = '{x: r_s1.x, y: r_s1.y, level: new_cell[CELL_W-1 -: LEVEL_W],
                           last: r_s1.last};

endmodule

`default_nettype wire

// ===== rtl/core/epr_out_fifo.sv =====
// Small result queue in front of the output channel.
`default_nettype none

module epr_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  epr_pkg::t_pix_res i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output epr_pkg::t_pix_res o_data
);
    import epr_pkg::*;

    localparam int PTR_W = $clog2(OFIFO_DEPTH);
    localparam int CNT_W = $clog2(OFIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OFIFO_DEPTH - 1);

    t_pix_res         r_buf [OFIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    // upstream holds a credit per entry, so a push never finds the queue full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/epr_checker.sv =====
// Port-level checks for the pixel response model, bound to the top level.
`default_nettype none

module epr_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [epr_pkg::X_W-1:0]     i_out_x,
    input  logic [epr_pkg::Y_W-1:0]     i_out_y,
    input  logic [epr_pkg::LEVEL_W-1:0] i_out_level,
    input  logic                        i_out_last
);
    import epr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable({i_out_x, i_out_y, i_out_level, i_out_last}))
        else $error("output transaction changed while stalled");

    // the clearing pass keeps the input closed right after reset
    a_clear_blocks_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // reset empties the result queue
    a_reset_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind epaper_pixel_response_model epr_checker u_epr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_x     (o_out.pixel_x),
    .i_out_y     (o_out.pixel_y),
    .i_out_level (o_out.pixel_level),
    .i_out_last  (o_out.last_of_item)
);

`default_nettype wire
